FILE: src/plen_pkg.sv
`default_nettype none
package plen_pkg;

  localparam int unsigned MaxHosts   = 64;
  localparam int unsigned NumW       = 31;
  localparam int unsigned ValW       = 32;
  localparam int unsigned HostCntW   = 7;
  localparam int unsigned GrantLimit = (MaxHosts < 127) ? MaxHosts : 127;
  localparam logic [HostCntW-1:0] GrantMax = HostCntW'(GrantLimit);

  typedef enum logic [2:0] {
    OP_BEGIN     = 3'd0,
    OP_PREP_RPLY = 3'd1,
    OP_END_PREP  = 3'd2,
    OP_ACC_RPLY  = 3'd3,
    OP_END_ACC   = 3'd4,
    OP_PREP_REQ  = 3'd5,
    OP_ACC_REQ   = 3'd6,
    OP_LEARN     = 3'd7
  } opcode_t;

  typedef enum logic {
    REG_LIVE_HOSTS = 1'b0,
    REG_OWN_ADDR   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic            ok;
    logic [NumW-1:0] number_out;
    logic [ValW-1:0] value_out;
    logic [ValW-1:0] leader;
    logic [ValW-1:0] election_round;
  } result_t;

endpackage
`default_nettype wire

FILE: src/paxos_leader_election_node_core.sv
`default_nettype none
// Each accepted beat's result is registered in out_r, or in skid_r while the output stalls.
// Throughput: one event per cycle while out_ready is high; with a result
// waiting, one more beat lands in the skid register, then in_ready drops until the output drains.
// Reset: synchronous active-low rst_n clears all protocol state, the
// configuration registers and the valid flags of both output buffer entries.
module paxos_leader_election_node_core
  import plen_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [2:0]          in_opcode,
  input  wire logic                in_granted,
  input  wire logic [NumW-1:0]     in_number,
  input  wire logic [ValW-1:0]     in_value,

  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_ok,
  output logic [NumW-1:0]          out_number_out,
  output logic [ValW-1:0]          out_value_out,
  output logic [ValW-1:0]          out_leader,
  output logic [ValW-1:0]          out_election_round,

  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [2:0]          cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);

  logic [HostCntW-1:0] live_hosts_r;
  logic [ValW-1:0]     own_addr_r;

  logic [NumW-1:0]     promised_r,  promised_nxt;
  logic [NumW-1:0]     acc_num_r,   acc_num_nxt;
  logic [ValW-1:0]     acc_val_r,   acc_val_nxt;
  logic [ValW-1:0]     leader_r,    leader_nxt;
  logic [ValW-1:0]     prev_lead_r, prev_lead_nxt;
  logic [ValW-1:0]     round_r,     round_nxt;
  logic [NumW-1:0]     prop_num_r,  prop_num_nxt;
  logic                best_vld_r,  best_vld_nxt;
  logic [NumW-1:0]     best_num_r,  best_num_nxt;
  logic [ValW-1:0]     cand_r,      cand_nxt;
  logic [HostCntW-1:0] grants_r,    grants_nxt;

  result_t             res_nxt;
  result_t             out_r;
  result_t             skid_r;
  logic                out_vld_r;
  logic                skid_vld_r;

  logic                in_fire;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;
  opcode_t             op;
  logic [HostCntW-2:0] thresh;
  logic [HostCntW-1:0] grants_inc;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_comb begin
    case (cfg_idx)
      REG_LIVE_HOSTS: cfg_prdata = {{(32-HostCntW){1'b0}}, live_hosts_r};
      REG_OWN_ADDR:   cfg_prdata = own_addr_r;
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_hosts_r <= '0;
      own_addr_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LIVE_HOSTS: live_hosts_r <= cfg_pwdata[HostCntW-1:0];
        REG_OWN_ADDR:   own_addr_r   <= cfg_pwdata;
        default:        ;
      endcase
    end
  end

  assign in_ready = !skid_vld_r;
  assign in_fire  = in_valid & in_ready;
  assign op       = opcode_t'(in_opcode);
  assign thresh   = live_hosts_r[HostCntW-1:1];
  assign grants_inc = (grants_r < GrantMax) ? grants_r + 1'b1 : grants_r;

  always_comb begin
    promised_nxt  = promised_r;
    acc_num_nxt   = acc_num_r;
    acc_val_nxt   = acc_val_r;
    leader_nxt    = leader_r;
    prev_lead_nxt = prev_lead_r;
    round_nxt     = round_r;
    prop_num_nxt  = prop_num_r;
    best_vld_nxt  = best_vld_r;
    best_num_nxt  = best_num_r;
    cand_nxt      = cand_r;
    grants_nxt    = grants_r;
    res_nxt       = '0;
    res_nxt.ok    = 1'b0;

    case (op)
      OP_BEGIN: begin
        prev_lead_nxt = leader_r;
        prop_num_nxt  = (&promised_r) ? promised_r : promised_r + 1'b1;
        cand_nxt      = own_addr_r;
        best_vld_nxt  = 1'b0;
        best_num_nxt  = '0;
        grants_nxt    = '0;
      end
      OP_PREP_RPLY: begin
        if (in_granted) begin
          grants_nxt = grants_inc;
          if (in_value != prev_lead_r && (!best_vld_r || in_number > best_num_r)) begin
            best_vld_nxt = 1'b1;
            best_num_nxt = in_number;
            cand_nxt     = in_value;
          end
        end
        res_nxt.ok = grants_nxt >= {1'b0, thresh};
      end
      OP_END_PREP: begin
        res_nxt.ok = grants_r >= {1'b0, thresh};
        grants_nxt = '0;
      end
      OP_ACC_RPLY: begin
        if (in_granted) begin
          grants_nxt = grants_inc;
        end
        res_nxt.ok = grants_nxt >= {1'b0, thresh};
      end
      OP_END_ACC: begin
        res_nxt.ok = grants_r >= {1'b0, thresh};
        if (res_nxt.ok) begin
          leader_nxt = acc_val_r;
          round_nxt  = round_r + 1'b1;
        end
        grants_nxt = '0;
      end
      OP_PREP_REQ: begin
        if (in_number > promised_r) begin
          promised_nxt = in_number;
          res_nxt.ok   = 1'b1;
        end
      end
      OP_ACC_REQ: begin
        if (in_number >= promised_r) begin
          promised_nxt = in_number;
          acc_num_nxt  = in_number;
          acc_val_nxt  = in_value;
          res_nxt.ok   = 1'b1;
        end
      end
      OP_LEARN: begin
        leader_nxt  = acc_val_r;
        round_nxt   = round_r + 1'b1;
        acc_val_nxt = '0;
        res_nxt.ok  = 1'b1;
      end
      default: ;
    endcase

    if (op == OP_PREP_REQ && res_nxt.ok) begin
      res_nxt.number_out = acc_num_r;
      res_nxt.value_out  = acc_val_r;
    end else if (op == OP_LEARN) begin
      res_nxt.number_out = prop_num_nxt;
      res_nxt.value_out  = acc_val_r;
    end else begin
      res_nxt.number_out = prop_num_nxt;
      res_nxt.value_out  = cand_nxt;
    end
    res_nxt.leader         = leader_nxt;
    res_nxt.election_round = round_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      promised_r  <= '0;
      acc_num_r   <= '0;
      acc_val_r   <= '0;
      leader_r    <= '0;
      prev_lead_r <= '0;
      round_r     <= '0;
      prop_num_r  <= '0;
      best_vld_r  <= 1'b0;
      best_num_r  <= '0;
      cand_r      <= '0;
      grants_r    <= '0;
    end else if (in_fire) begin
      promised_r  <= promised_nxt;
      acc_num_r   <= acc_num_nxt;
      acc_val_r   <= acc_val_nxt;
      leader_r    <= leader_nxt;
      prev_lead_r <= prev_lead_nxt;
      round_r     <= round_nxt;
      prop_num_r  <= prop_num_nxt;
      best_vld_r  <= best_vld_nxt;
      best_num_r  <= best_num_nxt;
      cand_r      <= cand_nxt;
      grants_r    <= grants_nxt;
    end
  end

  // output register plus skid entry; skid beat is always the younger one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_ready) begin
      out_vld_r  <= skid_vld_r | in_fire;
      skid_vld_r <= 1'b0;
    end else if (in_fire) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_ready) begin
      if (skid_vld_r) begin
        out_r <= skid_r;
      end else if (in_fire) begin
        out_r <= res_nxt;
      end
    end else if (in_fire) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_ok             = out_r.ok;
  assign out_number_out     = out_r.number_out;
  assign out_value_out      = out_r.value_out;
  assign out_leader         = out_r.leader;
  assign out_election_round = out_r.election_round;

endmodule
`default_nettype wire

FILE: sim/tb.sv
module tb;
  import plen_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_opcode = 3'd0;
  logic in_granted = 1'b0;
  logic [NumW-1:0] in_number = '0;
  logic [ValW-1:0] in_value = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  logic out_ok;
  logic [NumW-1:0] out_number_out;
  logic [ValW-1:0] out_value_out;
  logic [ValW-1:0] out_leader;
  logic [ValW-1:0] out_election_round;

  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  paxos_leader_election_node_core dut (.*);

  typedef struct {
    opcode_t op;
    logic g;
    logic [NumW-1:0] num;
    logic [ValW-1:0] val;
    bit typed;
    result_t want;
  } step_row_t;

  logic [HostCntW-1:0] c_live = '0;
  logic [ValW-1:0] c_own = '0;

  logic [NumW-1:0] n_promised = '0;
  logic [NumW-1:0] n_acc_num = '0;
  logic [ValW-1:0] n_acc_val = '0;
  logic [ValW-1:0] n_leader = '0;
  logic [ValW-1:0] n_prev_leader = '0;
  logic [ValW-1:0] n_round = '0;
  logic [NumW-1:0] n_proposal = '0;
  logic n_best_ok = 1'b0;
  logic [NumW-1:0] n_best_num = '0;
  logic [ValW-1:0] n_candidate = '0;
  logic [HostCntW-1:0] n_grants = '0;

  result_t pending[$];
  result_t got;
  result_t want;
  int errors = 0;
  int events_sent = 0;
  int beats_checked = 0;
  int settings_used = 0;
  bit steady = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit quorum();
    return n_grants >= (c_live >> 1);
  endfunction

  function automatic result_t apply_event(opcode_t op, logic g, logic [NumW-1:0] num,
                                          logic [ValW-1:0] val);
    result_t r;
    logic ok;
    logic prep_grant;
    logic is_learn;
    logic [ValW-1:0] learned;
    ok = 1'b0;
    prep_grant = 1'b0;
    is_learn = 1'b0;
    learned = '0;
    case (op)
      OP_BEGIN: begin
        n_prev_leader = n_leader;
        n_proposal = (n_promised == '1) ? n_promised : n_promised + 1'b1;
        n_candidate = c_own;
        n_best_ok = 1'b0;
        n_best_num = '0;
        n_grants = '0;
      end
      OP_PREP_RPLY: begin
        if (g) begin
          if (n_grants < GrantMax) n_grants = n_grants + 1'b1;
          if (val != n_prev_leader && (!n_best_ok || num > n_best_num)) begin
            n_best_ok = 1'b1;
            n_best_num = num;
            n_candidate = val;
          end
        end
        ok = quorum();
      end
      OP_END_PREP: begin
        ok = quorum();
        n_grants = '0;
      end
      OP_ACC_RPLY: begin
        if (g && n_grants < GrantMax) n_grants = n_grants + 1'b1;
        ok = quorum();
      end
      OP_END_ACC: begin
        ok = quorum();
        if (ok) begin
          n_leader = n_acc_val;
          n_round = n_round + 1;
        end
        n_grants = '0;
      end
      OP_PREP_REQ: begin
        if (num > n_promised) begin
          n_promised = num;
          ok = 1'b1;
          prep_grant = 1'b1;
        end
      end
      OP_ACC_REQ: begin
        if (num >= n_promised) begin
          n_acc_num = num;
          n_acc_val = val;
          n_promised = num;
          ok = 1'b1;
        end
      end
      default: begin
        learned = n_acc_val;
        is_learn = 1'b1;
        n_leader = n_acc_val;
        n_round = n_round + 1;
        n_acc_val = '0;
        ok = 1'b1;
      end
    endcase
    r.ok = ok;
    r.number_out = prep_grant ? n_acc_num : n_proposal;
    r.value_out = prep_grant ? n_acc_val : (is_learn ? learned : n_candidate);
    r.leader = n_leader;
    r.election_round = n_round;
    return r;
  endfunction

  function automatic step_row_t ev(opcode_t op, logic g, logic [NumW-1:0] num,
                                   logic [ValW-1:0] val, bit typed = 1'b0,
                                   result_t want = '0);
    step_row_t s;
    s.op = op;
    s.g = g;
    s.num = num;
    s.val = val;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  function automatic logic [NumW-1:0] pick_num();
    logic [31:0] t;
    case ($urandom_range(0, 4))
      0: return n_promised;
      1: begin
        t = {1'b0, n_promised} + $urandom_range(1, 5);
        return (t > 32'h7FFF_FFFF) ? '1 : t[NumW-1:0];
      end
      2: begin
        t = $urandom_range(0, 3);
        return (n_promised < t[NumW-1:0]) ? '0 : n_promised - t[NumW-1:0];
      end
      3: return NumW'($urandom_range(0, 40));
      default: return NumW'($urandom);
    endcase
  endfunction

  function automatic logic [ValW-1:0] pick_val();
    case ($urandom_range(0, 3))
      0: return n_prev_leader;
      1: return c_own;
      2: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_event(opcode_t op, logic g, logic [NumW-1:0] num, logic [ValW-1:0] val,
                            bit typed = 1'b0, result_t want = '0);
    result_t r;
    while (!steady && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_granted <= g;
    in_number <= num;
    in_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = apply_event(op, g, num, val);
    pending.push_back(typed ? want : r);
    events_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    logic [31:0] readback;
    readback = (idx == REG_LIVE_HOSTS) ? {25'd0, data[HostCntW-1:0]} : data;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== readback) begin
      $error("prdata: expected %0h, got %0h", readback, cfg_prdata);
      errors++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == REG_LIVE_HOSTS) c_live = data[HostCntW-1:0];
    else c_own = data;
  endtask

  task automatic run_round();
    int k;
    int m;
    send_event(OP_BEGIN, 1'($urandom_range(0, 1)), pick_num(), $urandom);
    k = ($urandom_range(0, 24) == 0) ? $urandom_range(75, 95)
                                     : $urandom_range(0, c_live / 2 + 2);
    repeat (k) begin
      send_event(OP_PREP_RPLY, $urandom_range(0, 99) < 80,
                 $urandom_range(0, 1) ? NumW'($urandom_range(0, 40)) : NumW'($urandom),
                 pick_val());
    end
    send_event(OP_END_PREP, 1'($urandom_range(0, 1)), pick_num(), $urandom);
    if ($urandom_range(0, 3) != 0)
      send_event(OP_PREP_REQ, 1'($urandom_range(0, 1)), pick_num(), $urandom);
    send_event(OP_ACC_REQ, 1'($urandom_range(0, 1)), pick_num(), pick_val());
    m = ($urandom_range(0, 24) == 0) ? $urandom_range(75, 95)
                                     : $urandom_range(0, c_live / 2 + 2);
    repeat (m) begin
      send_event(OP_ACC_RPLY, $urandom_range(0, 99) < 80, pick_num(), $urandom);
    end
    send_event(OP_END_ACC, 1'($urandom_range(0, 1)), pick_num(), $urandom);
    if ($urandom_range(0, 2) == 0)
      send_event(OP_LEARN, 1'($urandom_range(0, 1)), pick_num(), $urandom);
  endtask

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 27);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got.ok = out_ok;
      got.number_out = out_number_out;
      got.value_out = out_value_out;
      got.leader = out_leader;
      got.election_round = out_election_round;
      if (pending.size() == 0) begin
        $error("result beat with no event outstanding");
        errors++;
      end else begin
        want = pending.pop_front();
        beats_checked++;
        if (got.ok !== want.ok) begin
          $error("ok: expected %0h, got %0h", want.ok, got.ok);
          errors++;
        end
        if (got.number_out !== want.number_out) begin
          $error("number_out: expected %0h, got %0h", want.number_out, got.number_out);
          errors++;
        end
        if (got.value_out !== want.value_out) begin
          $error("value_out: expected %0h, got %0h", want.value_out, got.value_out);
          errors++;
        end
        if (got.leader !== want.leader) begin
          $error("leader: expected %0h, got %0h", want.leader, got.leader);
          errors++;
        end
        if (got.election_round !== want.election_round) begin
          $error("election_round: expected %0h, got %0h",
                 want.election_round, got.election_round);
          errors++;
        end
      end
    end
  end

  initial begin
    #400000;
    $display("paxos_leader_election_node_core test failed");
    $finish;
  end

  initial begin
    step_row_t script[$];
    int target;
    logic [HostCntW-1:0] live;
    logic [ValW-1:0] own;

    script.push_back(ev(OP_END_PREP, 1'b0, 31'd0, 32'd0, 1'b1,
                        {1'b1, 31'd0, 32'd0, 32'd0, 32'd0}));
    script.push_back(ev(OP_LEARN, 1'b1, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                        {1'b1, 31'd0, 32'd0, 32'd0, 32'd1}));
    script.push_back(ev(OP_PREP_REQ, 1'b1, 31'd0, 32'hFFFF_FFFF, 1'b1,
                        {1'b0, 31'd0, 32'd0, 32'd0, 32'd1}));
    script.push_back(ev(OP_ACC_REQ, 1'b0, 31'd0, 32'h1234_5678, 1'b1,
                        {1'b1, 31'd0, 32'd0, 32'd0, 32'd1}));
    script.push_back(ev(OP_PREP_REQ, 1'b0, 31'h7FFF_FFFF, 32'd0, 1'b1,
                        {1'b1, 31'd0, 32'h1234_5678, 32'd0, 32'd1}));
    script.push_back(ev(OP_ACC_REQ, 1'b1, 31'h7FFF_FFFE, 32'h5555_AAAA, 1'b1,
                        {1'b0, 31'd0, 32'd0, 32'd0, 32'd1}));
    script.push_back(ev(OP_ACC_REQ, 1'b1, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                        {1'b1, 31'd0, 32'd0, 32'd0, 32'd1}));
    script.push_back(ev(OP_BEGIN, 1'b0, 31'd0, 32'd0, 1'b1,
                        {1'b0, 31'h7FFF_FFFF, 32'd0, 32'd0, 32'd1}));
    script.push_back(ev(OP_PREP_RPLY, 1'b1, 31'd5, 32'd0, 1'b1,
                        {1'b1, 31'h7FFF_FFFF, 32'd0, 32'd0, 32'd1}));
    script.push_back(ev(OP_PREP_RPLY, 1'b0, 31'h7FFF_FFFF, 32'hAAAA_5555));
    script.push_back(ev(OP_PREP_RPLY, 1'b1, 31'd3, 32'hCAFE_0001));
    script.push_back(ev(OP_PREP_RPLY, 1'b1, 31'd2, 32'hCAFE_0002));
    script.push_back(ev(OP_PREP_RPLY, 1'b1, 31'h7FFF_FFFF, 32'h0000_0001));
    script.push_back(ev(OP_END_PREP, 1'b1, 31'h7FFF_FFFF, 32'hFFFF_FFFF));
    script.push_back(ev(OP_ACC_RPLY, 1'b0, 31'd0, 32'd0));
    script.push_back(ev(OP_ACC_RPLY, 1'b1, 31'h7FFF_FFFF, 32'hFFFF_FFFF));
    script.push_back(ev(OP_END_ACC, 1'b0, 31'd0, 32'd0));
    script.push_back(ev(OP_LEARN, 1'b0, 31'd0, 32'h0BAD_F00D));
    script.push_back(ev(OP_END_ACC, 1'b1, 31'd1, 32'd1));
    script.push_back(ev(OP_PREP_REQ, 1'b1, 31'h7FFF_FFFF, 32'd7));
    script.push_back(ev(OP_BEGIN, 1'b1, 31'h7FFF_FFFF, 32'hFFFF_FFFF));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      send_event(script[i].op, script[i].g, script[i].num, script[i].val,
                 script[i].typed, script[i].want);
    end
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin live = 7'd64; own = 32'hFFFF_FFFF; end
        1: begin live = 7'd1; own = 32'd0; end
        2: begin live = 7'd2; own = $urandom; end
        3: begin live = 7'd3; own = $urandom; end
        4: begin live = 7'd0; own = $urandom; end
        5: begin live = 7'd64; own = $urandom; end
        6: begin live = 7'($urandom_range(0, 64)); own = $urandom; end
        default: begin live = 7'($urandom_range(4, 20)); own = $urandom; end
      endcase
      write_reg(REG_LIVE_HOSTS, {25'd0, live});
      write_reg(REG_OWN_ADDR, own);
      settings_used++;
      steady = (phase == 2);
      target = events_sent + 175;
      while (events_sent < target) begin
        if ($urandom_range(0, 99) < 80) begin
          run_round();
        end else begin
          repeat ($urandom_range(1, 6)) begin
            send_event(opcode_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                       pick_num(), $urandom);
          end
        end
      end
      drain();
    end

    repeat (6) @(posedge clk);
    if (pending.size() != 0) begin
      $error("%0d results never arrived", pending.size());
      errors++;
    end
    $display("Sent %0d events under %0d register settings after the reset defaults;",
             events_sent, settings_used);
    $display("checked %0d result beats, model finished at election round %0d.",
             beats_checked, n_round);
    if (errors == 0) begin
      $display("paxos_leader_election_node_core test passed");
    end else begin
      $display("paxos_leader_election_node_core test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/plen_pkg.sv
src/paxos_leader_election_node_core.sv
sim/tb.sv
